// ----- src/srf_pkg.sv -----
package srf_pkg;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 7;
    localparam int INDEX_W  = 32;
    localparam int SCOUNT_W = 5;
    localparam int TDATA_W  = 16;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic CFG_SLOT_COUNT = 1'b0;
    localparam logic CFG_MAX_INDEX  = 1'b1;

    typedef enum logic [2:0] {
        STS_POP_BYTE  = 3'd0,
        STS_PUSH_OK   = 3'd1,
        STS_TOO_LONG  = 3'd2,
        STS_OVERFLOW  = 3'd3,
        STS_FULL      = 3'd4,
        STS_EMPTY     = 3'd5,
        STS_CAP_SHORT = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_LEN,
        ST_POP_DATA,
        ST_MOD
    } state_t;

endpackage

// ----- src/slotted_record_fifo.sv -----
// slotted_record_fifo: ring queue of byte records, one fixed slot per record
//
// s_axis carries requests: tuser 0 pushes one record byte (tdata[7:0], tlast on
// the final byte), tuser 1 pops the oldest record if it fits tdata[14:8] bytes.
// m_axis carries results: tuser is the status, tdata[7:0] the popped byte,
// tdata[14:8] the record length, tlast marks the final result of a request.
// cfg writes slot_count (index 0) or max_index (index 1).
//
// a push byte that is not last gives no result; a last push byte gives its
// status in the cycle after acceptance. a pop reads the length memory, then
// streams one byte per cycle from the byte memory while m_axis_tready stays
// high; requests are not taken while a pop streams. a write of slot_count
// re-maps both queue indices to slot numbers with a bit-serial remainder,
// with s_axis held off.
// when m_axis_tready is low the result register holds and the pop stream
// pauses; new requests wait until the result register can be loaded.
// reset empties the queue and clears the pending push; the slot memories are
// not cleared and hold nothing meaningful until written.
module slotted_record_fifo
    import srf_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int SLOT_BYTES = 64
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [TDATA_W-1:0]  s_axis_tdata,   // data_byte[7:0], pop_capacity[14:8], zero
    input  logic                s_axis_tuser,   // req_type
    input  logic                s_axis_tlast,   // push_last
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [TDATA_W-1:0]  m_axis_tdata,   // out_byte[7:0], record_length[14:8], zero
    output logic [2:0]          m_axis_tuser,   // status
    output logic                m_axis_tlast,   // last
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [INDEX_W-1:0]  cfg_data
);

    localparam int DEPTH = SLOTS * SLOT_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [DATA_W-1:0] byte_mem [DEPTH];
    logic [LEN_W-1:0]  len_mem  [SLOTS];

    state_t              state_reg, state_next;
    logic [SCOUNT_W-1:0] scount_reg, scount_next;
    logic [INDEX_W-1:0]  max_reg, max_next;
    logic [INDEX_W-1:0]  wr_reg, wr_next;
    logic [INDEX_W-1:0]  rd_reg, rd_next;
    logic [SW-1:0]       wslot_reg, wslot_next;
    logic [SW-1:0]       rslot_reg, rslot_next;
    logic [LEN_W-1:0]    pcnt_reg, pcnt_next;
    logic                ptl_reg, ptl_next;
    logic [4:0]          mcnt_reg, mcnt_next;
    logic [LEN_W-1:0]    cap_reg, cap_next;
    logic [LEN_W-1:0]    plen_reg, plen_next;
    logic [LEN_W-1:0]    iss_reg, iss_next;
    logic [LEN_W-1:0]    emit_reg, emit_next;
    logic [AW-1:0]       base_reg, base_next;
    logic                pend_reg, pend_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic                out_last_reg, out_last_next;

    logic [DATA_W-1:0]   byte_rdata_reg;
    logic [LEN_W-1:0]    len_rdata_reg;

    logic                bmem_we, bmem_re, lmem_we, lmem_re;
    logic [AW-1:0]       bmem_waddr, bmem_raddr;
    logic [DATA_W-1:0]   bmem_wdata;
    logic [SW-1:0]       lmem_waddr, lmem_raddr;
    logic [LEN_W-1:0]    lmem_wdata;

    logic [31:0]         n32;
    logic                out_free;
    logic                in_acc;

    logic [LEN_W-1:0]    push_len;
    logic                tl_new;
    logic                q_empty;
    logic [INDEX_W-1:0]  wr_e, rd_e;
    logic [SW-1:0]       ws_e, rs_e, ws_inc, rs_inc;
    logic                fits;
    logic [LEN_W-1:0]    pop_len;
    logic [4:0]          bit_sel;
    logic [SW:0]         wshift, rshift;
    logic [SW:0]         wrem, rrem;

    always_comb
    begin
        n32 = 32'(scount_reg);
        if (n32 == 32'd0)
        begin
            n32 = 32'd1;
        end
        if (n32 > 32'(SLOTS))
        begin
            n32 = 32'(SLOTS);
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free && !cfg_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_len_reg, out_byte_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // push path, plus pop slot step and pop length
    always_comb
    begin
        push_len = (pcnt_reg == 7'd127) ? 7'd127 : pcnt_reg + 7'd1;
        tl_new   = ptl_reg || (push_len > LEN_W'(SLOT_BYTES));
        q_empty  = (wr_reg == rd_reg);
        wr_e     = q_empty ? '0 : wr_reg;
        rd_e     = q_empty ? '0 : rd_reg;
        ws_e     = q_empty ? '0 : wslot_reg;
        rs_e     = q_empty ? '0 : rslot_reg;
        fits     = (wr_e != max_reg) && ((wr_e - rd_e) < n32);
        ws_inc   = ((32'(ws_e) + 32'd1) == n32) ? '0 : SW'(32'(ws_e) + 32'd1);
        rs_inc   = ((32'(rslot_reg) + 32'd1) == n32) ? '0 : SW'(32'(rslot_reg) + 32'd1);
        pop_len  = (len_rdata_reg > LEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES) : len_rdata_reg;
    end

    // bit-serial remainder of both indices by the slot count
    always_comb
    begin
        bit_sel = 5'd31 - mcnt_reg;
        wshift  = {wslot_reg, wr_reg[bit_sel]};
        rshift  = {rslot_reg, rd_reg[bit_sel]};
        wrem    = (32'(wshift) >= n32) ? (SW + 1)'(32'(wshift) - n32) : wshift;
        rrem    = (32'(rshift) >= n32) ? (SW + 1)'(32'(rshift) - n32) : rshift;
    end

    always_comb
    begin
        state_next      = state_reg;
        scount_next     = scount_reg;
        max_next        = max_reg;
        wr_next         = wr_reg;
        rd_next         = rd_reg;
        wslot_next      = wslot_reg;
        rslot_next      = rslot_reg;
        pcnt_next       = pcnt_reg;
        ptl_next        = ptl_reg;
        mcnt_next       = mcnt_reg;
        cap_next        = cap_reg;
        plen_next       = plen_reg;
        iss_next        = iss_reg;
        emit_next       = emit_reg;
        base_next       = base_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        bmem_we         = 1'b0;
        bmem_waddr      = AW'(32'(ws_e) * 32'(SLOT_BYTES) + 32'(pcnt_reg));
        bmem_wdata      = s_axis_tdata[DATA_W-1:0];
        bmem_re         = 1'b0;
        bmem_raddr      = AW'(32'(base_reg) + 32'(iss_reg));
        lmem_we         = 1'b0;
        lmem_waddr      = ws_e;
        lmem_wdata      = push_len;
        lmem_re         = 1'b0;
        lmem_raddr      = rslot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_index == CFG_SLOT_COUNT)
                    begin
                        scount_next = cfg_data[SCOUNT_W-1:0];
                        mcnt_next   = '0;
                        wslot_next  = '0;
                        rslot_next  = '0;
                        state_next  = ST_MOD;
                    end
                    else
                    begin
                        max_next = cfg_data;
                    end
                end
                else if (in_acc && s_axis_tuser == REQ_PUSH)
                begin
                    if (!tl_new)
                    begin
                        wr_next    = wr_e;
                        rd_next    = rd_e;
                        wslot_next = ws_e;
                        rslot_next = rs_e;
                        bmem_we    = fits;
                    end
                    if (s_axis_tlast)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        out_len_next   = push_len;
                        out_last_next  = 1'b1;
                        if (tl_new)
                        begin
                            out_status_next = STS_TOO_LONG;
                        end
                        else if (wr_e == max_reg)
                        begin
                            out_status_next = STS_OVERFLOW;
                        end
                        else if (!fits)
                        begin
                            out_status_next = STS_FULL;
                        end
                        else
                        begin
                            out_status_next = STS_PUSH_OK;
                            lmem_we         = 1'b1;
                            wr_next         = wr_e + 32'd1;
                            wslot_next      = ws_inc;
                        end
                        pcnt_next = '0;
                        ptl_next  = 1'b0;
                    end
                    else
                    begin
                        pcnt_next = push_len;
                        ptl_next  = tl_new;
                    end
                end
                else if (in_acc)
                begin
                    if (wr_reg <= rd_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STS_EMPTY;
                        out_byte_next   = '0;
                        out_len_next    = '0;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        lmem_re    = 1'b1;
                        cap_next   = s_axis_tdata[DATA_W +: LEN_W];
                        base_next  = AW'(32'(rslot_reg) * 32'(SLOT_BYTES));
                        state_next = ST_POP_LEN;
                    end
                end
            end

            ST_POP_LEN:
            begin
                if (cap_reg < pop_len)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STS_CAP_SHORT;
                        out_byte_next   = '0;
                        out_len_next    = pop_len;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (pop_len == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STS_POP_BYTE;
                        out_byte_next   = '0;
                        out_len_next    = '0;
                        out_last_next   = 1'b1;
                        rd_next         = rd_reg + 32'd1;
                        rslot_next      = rs_inc;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    rd_next    = rd_reg + 32'd1;
                    rslot_next = rs_inc;
                    plen_next  = pop_len;
                    iss_next   = '0;
                    emit_next  = '0;
                    pend_next  = 1'b0;
                    state_next = ST_POP_DATA;
                end
            end

            ST_POP_DATA:
            begin
                // byte read one ahead of the result register
                if (pend_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STS_POP_BYTE;
                    out_byte_next   = byte_rdata_reg;
                    out_len_next    = plen_reg;
                    out_last_next   = (emit_reg + 7'd1 == plen_reg);
                    emit_next       = emit_reg + 7'd1;
                    pend_next       = 1'b0;
                    if (emit_reg + 7'd1 == plen_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if ((iss_reg < plen_reg) && (!pend_reg || out_free))
                begin
                    bmem_re   = 1'b1;
                    iss_next  = iss_reg + 7'd1;
                    pend_next = 1'b1;
                end
            end

            ST_MOD:
            begin
                wslot_next = SW'(wrem);
                rslot_next = SW'(rrem);
                mcnt_next  = mcnt_reg + 5'd1;
                if (mcnt_reg == 5'd31)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scount_reg    <= 5'd16;
            max_reg       <= '1;
            wr_reg        <= '0;
            rd_reg        <= '0;
            wslot_reg     <= '0;
            rslot_reg     <= '0;
            pcnt_reg      <= '0;
            ptl_reg       <= 1'b0;
            mcnt_reg      <= '0;
            iss_reg       <= '0;
            emit_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scount_reg    <= scount_next;
            max_reg       <= max_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            wslot_reg     <= wslot_next;
            rslot_reg     <= rslot_next;
            pcnt_reg      <= pcnt_next;
            ptl_reg       <= ptl_next;
            mcnt_reg      <= mcnt_next;
            iss_reg       <= iss_next;
            emit_reg      <= emit_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg        <= cap_next;
        plen_reg       <= plen_next;
        base_reg       <= base_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    // record byte memory
    always_ff @(posedge clk)
    begin
        if (bmem_we)
        begin
            byte_mem[bmem_waddr] <= bmem_wdata;
        end
        if (bmem_re)
        begin
            byte_rdata_reg <= byte_mem[bmem_raddr];
        end
    end

    // record length memory
    always_ff @(posedge clk)
    begin
        if (lmem_we)
        begin
            len_mem[lmem_waddr] <= lmem_wdata;
        end
        if (lmem_re)
        begin
            len_rdata_reg <= len_mem[lmem_raddr];
        end
    end

endmodule

// ----- src/srf_checker.sv -----
module srf_checker
    import srf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [TDATA_W-1:0]  s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                s_axis_tlast,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [TDATA_W-1:0]  m_axis_tdata,
    input  logic [2:0]          m_axis_tuser,
    input  logic                m_axis_tlast,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [INDEX_W-1:0]  cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // every result other than a popped byte ends its request
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STS_POP_BYTE |-> m_axis_tlast)
        else $error("non-byte result without last");

    // only popped bytes carry data
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STS_POP_BYTE |-> m_axis_tdata[7:0] == 8'd0)
        else $error("data byte on a status result");

    // empty report carries no length
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STS_EMPTY |-> m_axis_tdata[14:8] == 7'd0)
        else $error("empty result with a length");

    // no request taken while a record is still streaming out
    a_no_req_mid_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STS_POP_BYTE && !m_axis_tlast
            |-> !(s_axis_tvalid && s_axis_tready))
        else $error("request taken during a pop");

endmodule

bind slotted_record_fifo srf_checker u_srf_checker (.*);

// ----- dv/tb_slotted_record_fifo.sv -----
`timescale 1ns / 1ps

module tb_slotted_record_fifo;
    import srf_pkg::*;

    localparam int SLOTS          = 16;
    localparam int SLOT_BYTES     = 64;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        status_t          status;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              last;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               s_axis_tuser;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [2:0]         m_axis_tuser;
    logic               m_axis_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [INDEX_W-1:0] cfg_data;

    // queue state as the block should hold it
    logic [DATA_W-1:0]   rec_bytes [SLOTS*SLOT_BYTES];
    bit                  rec_bytes_set [SLOTS*SLOT_BYTES];
    logic [LEN_W-1:0]    slot_len [SLOTS];
    bit                  slot_len_set [SLOTS];
    logic [INDEX_W-1:0]  q_wr_idx = '0;
    logic [INDEX_W-1:0]  q_rd_idx = '0;
    int unsigned         part_count = 0;
    bit                  part_long = 1'b0;
    logic [SCOUNT_W-1:0] slot_count_reg = 5'd16;
    logic [INDEX_W-1:0]  max_index_reg = 32'hFFFF_FFFF;

    result_t pending_results [$];

    int          fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned status_hits [8];
    bit          no_idle = 1'b0;
    int unsigned hold_len = 0;

    slotted_record_fifo #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned slots_for(input logic [SCOUNT_W-1:0] cnt);
        if (cnt == 0)
            return 1;
        if (cnt > SLOTS)
            return SLOTS;
        return 32'(cnt);
    endfunction

    function automatic void add_result(input status_t st, input logic [DATA_W-1:0] b,
                                       input int unsigned ln, input logic lst);
        result_t r;
        r.status = st;
        r.data   = b;
        r.len    = ln[LEN_W-1:0];
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // state update and expected results for one accepted request
    function automatic void apply_request(input logic kind, input logic [DATA_W-1:0] b,
                                          input logic lst, input logic [LEN_W-1:0] cap);
        int unsigned n, pos, ln, slot, i;
        logic [INDEX_W-1:0] used;
        status_t st;
        n = slots_for(slot_count_reg);
        if (kind == REQ_PUSH)
        begin
            pos = part_count;
            ln = (pos + 1 > 127) ? 127 : pos + 1;
            part_count = ln;
            if (ln > SLOT_BYTES)
                part_long = 1'b1;
            if (!part_long)
            begin
                if (q_wr_idx == q_rd_idx)
                begin
                    q_wr_idx = '0;
                    q_rd_idx = '0;
                end
                used = q_wr_idx - q_rd_idx;
                if (q_wr_idx != max_index_reg && used < n)
                begin
                    slot = q_wr_idx % n;
                    rec_bytes[slot*SLOT_BYTES + pos] = b;
                    rec_bytes_set[slot*SLOT_BYTES + pos] = 1'b1;
                end
            end
            if (lst)
            begin
                used = q_wr_idx - q_rd_idx;
                if (part_long)
                    st = STS_TOO_LONG;
                else if (q_wr_idx == max_index_reg)
                    st = STS_OVERFLOW;
                else if (used >= n)
                    st = STS_FULL;
                else
                begin
                    slot = q_wr_idx % n;
                    slot_len[slot] = ln[LEN_W-1:0];
                    slot_len_set[slot] = 1'b1;
                    q_wr_idx++;
                    st = STS_PUSH_OK;
                end
                add_result(st, '0, ln, 1'b1);
                part_count = 0;
                part_long = 1'b0;
            end
        end
        else if (q_wr_idx <= q_rd_idx)
            add_result(STS_EMPTY, '0, 0, 1'b1);
        else
        begin
            slot = q_rd_idx % n;
            ln = 32'(slot_len[slot]);
            if (ln > SLOT_BYTES)
                ln = SLOT_BYTES;
            if (cap < ln)
                add_result(STS_CAP_SHORT, '0, ln, 1'b1);
            else
            begin
                q_rd_idx++;
                if (ln == 0)
                    add_result(STS_POP_BYTE, '0, 0, 1'b1);
                for (i = 0; i < ln; i++)
                    add_result(STS_POP_BYTE, rec_bytes[slot*SLOT_BYTES + i], ln, i + 1 == ln);
            end
        end
    endfunction

    function automatic bit record_readable(input logic [INDEX_W-1:0] idx, input int unsigned n);
        int unsigned slot, i;
        slot = idx % n;
        if (!slot_len_set[slot])
            return 1'b0;
        for (i = 0; i < slot_len[slot]; i++)
            if (!rec_bytes_set[slot*SLOT_BYTES + i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit queue_readable(input int unsigned n);
        logic [INDEX_W-1:0] idx;
        for (idx = q_rd_idx; idx != q_wr_idx; idx++)
            if (!record_readable(idx, n))
                return 1'b0;
        return 1'b1;
    endfunction

    // would the record in progress either not commit or commit with all its slot bytes written
    function automatic bit commit_readable();
        int unsigned n, slot, i;
        logic [INDEX_W-1:0] w, r;
        n = slots_for(slot_count_reg);
        w = q_wr_idx;
        r = q_rd_idx;
        if (part_long || part_count + 1 > SLOT_BYTES)
            return 1'b1;
        if (w == r)
        begin
            w = '0;
            r = '0;
        end
        if (w == max_index_reg || w - r >= n)
            return 1'b1;
        slot = w % n;
        for (i = 0; i < part_count; i++)
            if (!rec_bytes_set[slot*SLOT_BYTES + i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [LEN_W-1:0] pick_capacity();
        int unsigned r, n;
        r = $urandom_range(99);
        n = slots_for(slot_count_reg);
        if (r < 50)
            return 7'd64;
        if (r < 80 || q_wr_idx <= q_rd_idx)
            return LEN_W'($urandom_range(64));
        return slot_len[q_rd_idx % n] - ($urandom_range(1) == 0 ? 7'd0 : 7'd1);
    endfunction

    // all driving tasks start and end at a falling edge
    task automatic send_req(input logic kind, input logic [DATA_W-1:0] b, input logic lst,
                            input logic [LEN_W-1:0] cap);
        while (!no_idle && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, cap, b};
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_request(kind, b, lst, cap);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_pop(input logic [LEN_W-1:0] cap);
        send_req(REQ_POP, DATA_W'($urandom_range(255)), 1'($urandom_range(1)), cap);
    endtask

    task automatic push_record(input int unsigned len, input bit mid_pop);
        int unsigned k;
        for (k = 0; k + 1 < len; k++)
        begin
            send_req(REQ_PUSH, DATA_W'($urandom_range(255)), 1'b0,
                     LEN_W'($urandom_range(64)));
            if (mid_pop && k == (len - 1) / 2)
                send_pop(pick_capacity());
        end
        // stretch past a slot so a commit never exposes unwritten bytes
        while (!commit_readable())
            send_req(REQ_PUSH, DATA_W'($urandom_range(255)), 1'b0,
                     LEN_W'($urandom_range(64)));
        send_req(REQ_PUSH, DATA_W'($urandom_range(255)), 1'b1, LEN_W'($urandom_range(64)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic drain_queue();
        while (q_wr_idx > q_rd_idx)
            send_pop(7'd64);
    endtask

    task automatic write_reg(input logic idx, input logic [INDEX_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_SLOT_COUNT)
            slot_count_reg = value[SCOUNT_W-1:0];
        else
            max_index_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_slot_count(input logic [SCOUNT_W-1:0] cnt);
        logic [INDEX_W-SCOUNT_W-1:0] upper;
        upper = (INDEX_W-SCOUNT_W)'($urandom);
        if (q_wr_idx != q_rd_idx && !queue_readable(slots_for(cnt)))
            drain_queue();
        write_reg(CFG_SLOT_COUNT, {upper, cnt});
    endtask

    task automatic run_traffic(input int unsigned n_items, input int unsigned push_pct);
        int unsigned stop_at, len, r;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < push_pct)
            begin
                r = $urandom_range(99);
                if (r < 3)
                    len = $urandom_range(70, 65);
                else if (r < 10)
                    len = $urandom_range(64, 50);
                else
                    len = $urandom_range(8, 1);
                push_record(len, $urandom_range(9) == 0);
            end
            else
                send_pop(pick_capacity());
        end
    endtask

    task automatic test_empty_and_single();
        send_pop(7'd64);
        send_req(REQ_PUSH, 8'hFF, 1'b1, 7'd0);
        send_pop(7'd0);
        send_pop(7'd64);
        send_req(REQ_PUSH, 8'h00, 1'b0, 7'd64);
        send_req(REQ_PUSH, 8'h5A, 1'b1, 7'd1);
        send_pop(7'd2);
        wait_drained();
    endtask

    task automatic test_full_and_overflow();
        set_slot_count(5'd1);
        push_record(1, 1'b0);
        push_record(1, 1'b0);
        send_pop(7'd64);
        set_slot_count(5'd0);
        push_record(2, 1'b0);
        push_record(1, 1'b0);
        drain_queue();
        set_slot_count(5'd2);
        write_reg(CFG_MAX_INDEX, 32'd1);
        push_record(1, 1'b0);
        push_record(1, 1'b0);
        drain_queue();
        write_reg(CFG_MAX_INDEX, 32'd0);
        push_record(1, 1'b0);
        write_reg(CFG_MAX_INDEX, 32'hFFFF_FFFF);
        set_slot_count(5'd31);
    endtask

    // pop lands mid-record, so the record commits over older bytes
    task automatic test_interleaved_pop();
        push_record(3, 1'b0);
        push_record(4, 1'b1);
        drain_queue();
        wait_drained();
    endtask

    task automatic test_slot_remap();
        set_slot_count(5'd4);
        push_record(2, 1'b0);
        push_record(3, 1'b0);
        push_record(4, 1'b0);
        push_record(5, 1'b0);
        send_pop(7'd64);
        set_slot_count(5'd3);
        drain_queue();
        set_slot_count(5'd16);
    endtask

    task automatic test_record_limits();
        push_record(64, 1'b0);
        send_pop(7'd63);
        send_pop(7'd64);
        push_record(128, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_len = HOLD_CYCLES;
        push_record(6, 1'b0);
        push_record(6, 1'b0);
        push_record(6, 1'b0);
        send_pop(7'd64);
        send_pop(7'd64);
        send_pop(7'd64);
        wait_drained();
    endtask

    task automatic test_random_phases();
        write_reg(CFG_MAX_INDEX, 32'hFFFF_FFFF);
        run_traffic(20, 55);
        set_slot_count(5'd3);
        run_traffic(15, 65);
        set_slot_count(5'd5);
        write_reg(CFG_MAX_INDEX, 32'd6);
        run_traffic(15, 70);
        set_slot_count(5'd31);
        write_reg(CFG_MAX_INDEX, 32'd2);
        run_traffic(10, 60);
        set_slot_count(SCOUNT_W'($urandom_range(31)));
        write_reg(CFG_MAX_INDEX, $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom_range(20, 1));
        run_traffic(15, 60);
    endtask

    task automatic test_burst();
        set_slot_count(5'd8);
        write_reg(CFG_MAX_INDEX, 32'h8000_0000);
        no_idle = 1'b1;
        run_traffic(40, 55);
        wait_drained();
        no_idle = 1'b0;
    endtask

    // receiver
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                hold_left = hold_len;
                hold_len = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= no_idle || $urandom_range(99) >= 37;
        end
    end

    // result checker
    initial
    begin
        result_t e;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                status_hits[m_axis_tuser]++;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result status %0d tdata %h last %b",
                             $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (m_axis_tuser !== e.status || m_axis_tdata[7:0] !== e.data
                        || m_axis_tdata[14:8] !== e.len || m_axis_tdata[15] !== 1'b0
                        || m_axis_tlast !== e.last)
                    begin
                        fail_count++;
                        $display({"%0t: mismatch expected status %0d byte %h len %0d last %b",
                                  ", actual status %0d byte %h len %0d last %b pad %b"},
                                 $realtime, e.status, e.data, e.len, e.last,
                                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[14:8],
                                 m_axis_tlast, m_axis_tdata[15]);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, WATCHDOG_LIMIT, pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PUSH;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_SLOT_COUNT;
        cfg_data      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_and_single();
        test_full_and_overflow();
        test_interleaved_pop();
        test_slot_remap();
        test_record_limits();
        test_backpressure();
        test_random_phases();
        test_burst();

        wait_drained();
        repeat (16) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $realtime,
                     pending_results.size());
        end
        $display("covered %0d requests and %0d results over several slot counts and limits",
                 items_sent, results_seen);
        $display({"pop bytes %0d, push ok %0d, too long %0d, overflow %0d, full %0d,",
                  " empty %0d, capacity short %0d"},
                 status_hits[STS_POP_BYTE], status_hits[STS_PUSH_OK],
                 status_hits[STS_TOO_LONG], status_hits[STS_OVERFLOW],
                 status_hits[STS_FULL], status_hits[STS_EMPTY], status_hits[STS_CAP_SHORT]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
